@@ sv/esp_pkg.sv @@
// Shared types, codes and command/status structures for the elevator sweep planner.
// Has no dependencies; every other file of the block imports it.
package esp_pkg;

    localparam int FLOORS  = 16;
    localparam int FLR_W   = $clog2(FLOORS);
    localparam int CNT_W   = $clog2(FLOORS + 1);
    localparam int DIST_W  = 6;
    localparam int FIELD_W = 5;

    typedef logic [FLR_W-1:0]   t_flr;
    typedef logic [1:0]         t_code;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [1:0]         t_action;

    // Stop codes held per floor.
    localparam t_code CODE_NONE = 2'd0;
    localparam t_code CODE_UP   = 2'd1;
    localparam t_code CODE_ANY  = 2'd2;
    localparam t_code CODE_DOWN = 2'd3;

    // Request kinds.
    localparam t_action ACT_CAB  = 2'd0;
    localparam t_action ACT_UP   = 2'd1;
    localparam t_action ACT_DOWN = 2'd2;
    localparam t_action ACT_RUN  = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic apply_req;
        logic start;
        logic step_cost;
        logic step_emit;
        logic choose;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_run;
        logic any_pending;
        logic out_free;
        logic cost_done;
        logic sel_done;
    } t_sts;

endpackage

@@ sv/esp_walk.sv @@
// Sweep walker: steps one floor per cycle while i_step is high, through one three-sweep plan.
// Depends on esp_pkg for floor, code, count and distance types.
module esp_walk import esp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_plan,
    input  logic                  i_start,
    input  logic                  i_step,
    input  t_code [FLOORS-1:0]    i_codes,
    input  t_flr                  i_cur,
    input  t_flr                  i_lo,
    input  t_flr                  i_hi,
    output logic                  o_done,
    output logic                  o_hit,
    output t_flr                  o_floor,
    output logic                  o_up,
    output t_dist                 o_dist,
    output t_flr                  o_pos,
    output t_cnt                  o_hits
);

    logic [1:0]        r_phase, n_phase;
    t_flr              r_l, n_l;
    logic              r_done, n_done;
    logic [FLOORS-1:0] r_used, n_used;
    t_flr              r_pos, n_pos;
    t_dist             r_dist, n_dist;
    t_cnt              r_hits, n_hits;

    logic  up;
    t_flr  target;
    t_code code;
    logic  hit;
    t_flr  delta;

    always_comb begin
        // Plan 0 sweeps down, up, down; plan 1 sweeps up, down, up.
        up = i_plan ? (r_phase != 2'd1) : (r_phase == 2'd1);
        case (r_phase)
            2'd0:    target = i_plan ? i_hi : i_lo;
            2'd1:    target = i_plan ? i_lo : i_hi;
            default: target = i_cur;
        endcase
        code  = i_codes[r_l];
        hit   = !r_done && !r_used[r_l] &&
                (up ? (code == CODE_UP   || code == CODE_ANY)
                    : (code == CODE_DOWN || code == CODE_ANY));
        delta = (r_l > r_pos) ? (r_l - r_pos) : (r_pos - r_l);
    end

    always_comb begin
        n_phase = r_phase;
        n_l     = r_l;
        n_done  = r_done;
        n_used  = r_used;
        n_pos   = r_pos;
        n_dist  = r_dist;
        n_hits  = r_hits;
        if (i_start) begin
            n_phase = 2'd0;
            n_l     = i_cur;
            n_done  = 1'b0;
            n_used  = '0;
            n_pos   = i_cur;
            n_dist  = '0;
            n_hits  = '0;
        end else if (i_step && !r_done) begin
            if (hit) begin
                n_used[r_l] = 1'b1;
                // Three sweeps over the floors never exceed the six-bit range.
                n_dist = r_dist + t_dist'(delta);
                n_pos  = r_l;
                n_hits = r_hits + t_cnt'(1);
            end
            if (r_l == target) begin
                if (r_phase == 2'd2) begin
                    n_done = 1'b1;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end else if (up) begin
                n_l = r_l + t_flr'(1);
            end else begin
                n_l = r_l - t_flr'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_l    <= n_l;
        r_used <= n_used;
        r_pos  <= n_pos;
        r_dist <= n_dist;
        r_hits <= n_hits;
    end

    assign o_done  = r_done;
    assign o_hit   = hit;
    assign o_floor = r_l;
    assign o_up    = up;
    assign o_dist  = r_dist;
    assign o_pos   = r_pos;
    assign o_hits  = r_hits;

endmodule

@@ sv/esp_ctrl.sv @@
// Controller state machine: sequences requests, plan costing and stop emission.
// Depends on esp_pkg for the command and status structures.
module esp_ctrl import esp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COST = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    if (!i_sts.in_run) begin
                        o_cmd.apply_req = 1'b1;
                    end else if (i_sts.any_pending) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_COST;
                    end
                end
            end
            ST_COST: begin
                if (i_sts.cost_done) begin
                    // Latch the cheaper plan and rewind the walkers to replay it.
                    o_cmd.choose = 1'b1;
                    o_cmd.start  = 1'b1;
                    n_state      = ST_EMIT;
                end else begin
                    o_cmd.step_cost = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_sts.sel_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.step_emit = i_sts.out_free;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/esp_dp.sv @@
// Datapath: stop map, car position and pending range, two plan walkers and the
// output register. Depends on esp_pkg and instantiates esp_walk twice.
module esp_dp import esp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    input  logic    i_s_tvalid,
    input  t_action i_action,
    input  t_field  i_floor,
    input  logic    i_cfg_valid,
    input  t_field  i_cfg_data,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_field  o_stop_floor,
    output logic    o_moving_up,
    output logic    o_pathway,
    output t_dist   o_distance,
    output logic    o_last
);

    t_code [FLOORS-1:0] r_map, n_map;
    t_flr               r_cur, n_cur;
    t_flr               r_lo, n_lo;
    t_flr               r_hi, n_hi;
    logic               r_path;
    t_dist              r_dsel;
    t_cnt               r_csel;
    t_flr               r_endpos;
    logic               r_mv;
    t_field             r_floor;
    logic               r_up;
    logic               r_last;
    logic               r_opath;
    t_dist              r_odist;

    t_code [FLOORS-1:0] eff_codes;
    logic               any_pending;
    logic               req_ok;
    t_flr               req_flr;
    t_code              req_code;
    logic               cfg_ok;
    t_flr               cfg_flr;
    logic               out_free;
    logic               load;

    logic  done0, done1, hit0, hit1, up0, up1;
    t_flr  floor0, floor1, pos0, pos1;
    t_dist dist0, dist1;
    t_cnt  hits0, hits1;

    logic  sel_hit, sel_up, sel_done;
    t_flr  sel_floor;
    t_cnt  sel_hits;

    // The run turns both ends of the pending range (r_lo and r_hi) into either-way stops.
    always_comb begin
        any_pending = 1'b0;
        for (int i = 0; i < FLOORS; i++) begin
            eff_codes[i] = (t_flr'(i) == r_lo || t_flr'(i) == r_hi) ? CODE_ANY : r_map[i];
            any_pending  = any_pending | (r_map[i] != CODE_NONE);
        end
    end

    always_comb begin
        req_ok  = (i_floor != '0) && (i_floor <= t_field'(FLOORS));
        req_flr = t_flr'(i_floor - t_field'(1));
        case (i_action)
            ACT_CAB:  req_code = CODE_ANY;
            ACT_UP:   req_code = CODE_UP;
            default:  req_code = CODE_DOWN;
        endcase
        cfg_ok  = (i_cfg_data != '0) && (i_cfg_data <= t_field'(FLOORS));
        cfg_flr = t_flr'(i_cfg_data - t_field'(1));
    end

    always_comb begin
        n_map = r_map;
        n_cur = r_cur;
        n_lo  = r_lo;
        n_hi  = r_hi;
        if (i_cmd.apply_req && req_ok) begin
            n_map[req_flr] = req_code;
            if (req_flr > r_hi) begin
                n_hi = req_flr;
            end
            if (req_flr < r_lo) begin
                n_lo = req_flr;
            end
        end
        if (i_cmd.finish) begin
            n_map = '0;
            n_cur = r_endpos;
            n_lo  = r_endpos;
            n_hi  = r_endpos;
        end
        if (i_cfg_valid && cfg_ok) begin
            n_cur = cfg_flr;
            n_lo  = cfg_flr;
            n_hi  = cfg_flr;
        end
    end

    esp_walk u_walk0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plan  (1'b0),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.step_cost | i_cmd.step_emit),
        .i_codes (eff_codes),
        .i_cur   (r_cur),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_done  (done0),
        .o_hit   (hit0),
        .o_floor (floor0),
        .o_up    (up0),
        .o_dist  (dist0),
        .o_pos   (pos0),
        .o_hits  (hits0)
    );

    esp_walk u_walk1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plan  (1'b1),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.step_cost | i_cmd.step_emit),
        .i_codes (eff_codes),
        .i_cur   (r_cur),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_done  (done1),
        .o_hit   (hit1),
        .o_floor (floor1),
        .o_up    (up1),
        .o_dist  (dist1),
        .o_pos   (pos1),
        .o_hits  (hits1)
    );

    always_comb begin
        sel_hit   = r_path ? hit1   : hit0;
        sel_up    = r_path ? up1    : up0;
        sel_done  = r_path ? done1  : done0;
        sel_floor = r_path ? floor1 : floor0;
        sel_hits  = r_path ? hits1  : hits0;
        out_free  = !r_mv || i_m_tready;
        load      = i_cmd.step_emit && sel_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
            r_cur <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
            r_mv  <= 1'b0;
        end else begin
            r_map <= n_map;
            r_cur <= n_cur;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            if (load) begin
                r_mv <= 1'b1;
            end else if (i_m_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path <= 1'b0;
        end else if (i_cmd.choose) begin
            // Plan 1 wins ties.
            r_path <= !(dist0 < dist1);
        end
        if (i_cmd.choose) begin
            r_dsel   <= (dist0 < dist1) ? dist0 : dist1;
            r_csel   <= (dist0 < dist1) ? hits0 : hits1;
            r_endpos <= (dist0 < dist1) ? pos0  : pos1;
        end
        // The plan fields travel with the stop, so a stalled stop keeps them
        // while the next run is already being costed.
        if (load) begin
            r_floor <= t_field'(sel_floor) + t_field'(1);
            r_up    <= sel_up;
            r_last  <= (sel_hits == r_csel - t_cnt'(1));
            r_opath <= r_path;
            r_odist <= r_dsel;
        end
    end

    always_comb begin
        o_sts.in_valid    = i_s_tvalid;
        o_sts.in_run      = (i_action == ACT_RUN);
        o_sts.any_pending = any_pending;
        o_sts.out_free    = out_free;
        o_sts.cost_done   = done0 && done1;
        o_sts.sel_done    = sel_done;
    end

    assign o_m_tvalid   = r_mv;
    assign o_stop_floor = r_floor;
    assign o_moving_up  = r_up;
    assign o_pathway    = r_opath;
    assign o_distance   = r_odist;
    assign o_last       = r_last;

endmodule

@@ sv/elevator_sweep_planner.sv @@
// Elevator sweep planner, top level: joins the controller and the datapath.
// Depends on esp_pkg, esp_ctrl, esp_dp (and through it esp_walk).
//
// Usage: the slave stream carries requests, tuser the action (cab, up call,
// down call, run) and tdata the floor. A cab or call request is applied in the
// idle state and leaves o_s_tready high, so requests can stream in one per cycle.
// A run with stops pending drops o_s_tready until its plan is served: both plans
// are walked side by side, one floor per cycle, then the cheaper plan is picked;
// the chosen plan is then replayed floor by floor, one floor per cycle while the
// output register is free, emitting each stop on the master stream with tlast
// on the final one. Back-pressure on the master side stalls the replay, never
// loses a stop. The first stop is loaded into the output register when the
// replay steps on the first stop floor. A run with nothing pending is accepted
// and yields nothing. The configuration channel is always ready and sets the
// car floor and the pending range when its value is a valid floor.
// Reset (synchronous, active low) clears all stops and parks the car on floor 1.
module elevator_sweep_planner import esp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [4:0] floor, [7:5] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [4:0] stop_floor, [5] moving_up, [6] pathway,
                                     // [12:7] distance_total, [15:13] zero
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data   // start_floor
);

    t_cmd   cmd;
    t_sts   sts;
    t_field stop_floor;
    logic   moving_up;
    logic   pathway;
    t_dist  distance;

    esp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    esp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_s_tvalid   (i_s_tvalid),
        .i_action     (i_s_tuser),
        .i_floor      (i_s_tdata[4:0]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_stop_floor (stop_floor),
        .o_moving_up  (moving_up),
        .o_pathway    (pathway),
        .o_distance   (distance),
        .o_last       (o_m_tlast)
    );

    assign o_s_tready  = cmd.in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {3'b000, distance, pathway, moving_up, stop_floor};

    // The replay only advances when the output register can take a stop.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step_emit |-> (!o_m_tvalid || i_m_tready))
        else $error("replay stepped while the output register was blocked");

    // Every emitted stop names a real floor.
    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (stop_floor != '0 && stop_floor <= t_field'(FLOORS)))
        else $error("stop floor out of range");

    // No new request is taken while a run is being planned or served.
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.start && !cmd.choose) |=> !o_s_tready)
        else $error("input accepted during a run");

endmodule
